// ===== hdl/tnref_pkg.sv =====
// Shared constants and types for the telnet option refuser.
package tnref_pkg;

    localparam int IDLE_WIDTH  = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int BYTE_WIDTH  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_WIDTH-1:0] MAX_IDLE_RESET = CFG_WIDTH'(60);

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [BYTE_WIDTH-1:0] CODE_IAC  = 8'd255;
    localparam logic [BYTE_WIDTH-1:0] CODE_WILL = 8'd251;
    localparam logic [BYTE_WIDTH-1:0] CODE_WONT = 8'd252;
    localparam logic [BYTE_WIDTH-1:0] CODE_DO   = 8'd253;
    localparam logic [BYTE_WIDTH-1:0] CODE_DONT = 8'd254;

    typedef enum logic [1:0] {
        DEST_CONSOLE = 2'd0,
        DEST_SEND    = 2'd1,
        DEST_CLOSE   = 2'd2
    } dest_t;

    typedef enum logic [1:0] {
        ACT_CONSOLE = 2'd0,
        ACT_REFUSE  = 2'd1,
        ACT_CLOSE   = 2'd2
    } act_kind_t;

    typedef struct packed {
        act_kind_t             kind;
        logic [BYTE_WIDTH-1:0] verb;
        logic [BYTE_WIDTH-1:0] data;
    } action_t;

endpackage

// ===== hdl/tnref_if.sv =====
// Handshake channel interfaces: input items, result items, configuration writes.
interface tnref_in_if import tnref_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [BYTE_WIDTH-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface tnref_out_if import tnref_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [1:0]            destination;
    logic [BYTE_WIDTH-1:0] out_byte;
    logic                  last_of_run;

    modport source (output valid, output destination, output out_byte, output last_of_run,
                    input ready);
    modport sink   (input valid, input destination, input out_byte, input last_of_run,
                    output ready);
endinterface

interface tnref_cfg_if import tnref_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_WIDTH-1:0] max_idle_ticks;

    modport source (output valid, output max_idle_ticks, input ready);
    modport sink   (input valid, input max_idle_ticks, output ready);
endinterface

// ===== hdl/tnref_front.sv =====
// Front end: telnet parser, idle counter and idle limit register.
module tnref_front import tnref_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tnref_in_if.sink     request,
    tnref_cfg_if.sink    cfg,
    input  logic         q_full,
    output logic         push,
    output action_t      act
);

    typedef enum logic [2:0] {
        PS_NORMAL = 3'd0,
        PS_IAC    = 3'd1,
        PS_WILL   = 3'd2,
        PS_WONT   = 3'd3,
        PS_DO     = 3'd4,
        PS_DONT   = 3'd5
    } parse_t;

    parse_t                 state_reg, state_next;
    logic [IDLE_WIDTH-1:0]  idle_reg, idle_next;
    logic [CFG_WIDTH-1:0]   max_reg, max_next;
    logic [IDLE_WIDTH-1:0]  idle_inc;
    logic                   accept;

    assign request.ready = !q_full;
    assign cfg.ready     = 1'b1;
    assign accept        = request.valid && request.ready;
    assign idle_inc      = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        idle_next  = idle_reg;
        max_next   = max_reg;
        push       = 1'b0;
        act.kind   = ACT_CONSOLE;
        act.verb   = '0;
        act.data   = request.data_byte;

        if (cfg.valid && cfg.ready)
        begin
            max_next = cfg.max_idle_ticks;
        end

        if (accept)
        begin
            if (request.command == CMD_TICK)
            begin
                if (max_reg != '0)
                begin
                    if (32'(idle_inc) >= 32'(max_reg))
                    begin
                        state_next = PS_NORMAL;
                        idle_next  = '0;
                        push       = 1'b1;
                        act.kind   = ACT_CLOSE;
                        act.data   = '0;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                    end
                end
            end
            else
            begin
                idle_next = '0;
                case (state_reg)
                    PS_IAC:
                    begin
                        case (request.data_byte)
                            CODE_IAC:
                            begin
                                state_next = PS_NORMAL;
                                push       = 1'b1;
                            end
                            CODE_WILL: state_next = PS_WILL;
                            CODE_WONT: state_next = PS_WONT;
                            CODE_DO:   state_next = PS_DO;
                            CODE_DONT: state_next = PS_DONT;
                            default:   state_next = PS_NORMAL;
                        endcase
                    end
                    PS_WILL, PS_WONT:
                    begin
                        state_next = PS_NORMAL;
                        push       = 1'b1;
                        act.kind   = ACT_REFUSE;
                        act.verb   = CODE_DONT;
                    end
                    PS_DO, PS_DONT:
                    begin
                        state_next = PS_NORMAL;
                        push       = 1'b1;
                        act.kind   = ACT_REFUSE;
                        act.verb   = CODE_WONT;
                    end
                    default:
                    begin
                        if (request.data_byte == CODE_IAC)
                        begin
                            state_next = PS_IAC;
                        end
                        else
                        begin
                            state_next = PS_NORMAL;
                            push       = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_NORMAL;
            idle_reg  <= '0;
            max_reg   <= MAX_IDLE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            idle_reg  <= idle_next;
            max_reg   <= max_next;
        end
    end

endmodule

// ===== hdl/tnref_queue.sv =====
// Short action queue between the parser and the reply generator.
module tnref_queue import tnref_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  action_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    empty,
    output action_t head
);

    action_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/tnref_back.sv =====
// Back end: expands queued actions into result items behind an output register.
module tnref_back import tnref_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  action_t     head,
    output logic        pop,
    tnref_out_if.source response
);

    localparam logic [1:0] REPLY_VERB = 2'd1;
    localparam logic [1:0] REPLY_OPT  = 2'd2;
    localparam logic [1:0] REPLY_LAST = 2'd3;

    logic                  out_valid_reg, out_valid_next;
    dest_t                 dest_reg, dest_next;
    logic [BYTE_WIDTH-1:0] byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic                  busy_reg, busy_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic [BYTE_WIDTH-1:0] verb_reg, verb_next;
    logic [BYTE_WIDTH-1:0] opt_reg, opt_next;
    logic                  load;

    assign load                 = !out_valid_reg || response.ready;
    assign pop                  = load && !busy_reg && !empty;
    assign response.valid       = out_valid_reg;
    assign response.destination = dest_reg;
    assign response.out_byte    = byte_reg;
    assign response.last_of_run = last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        dest_next      = dest_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        verb_next      = verb_reg;
        opt_next       = opt_reg;

        if (load)
        begin
            if (busy_reg)
            begin
                out_valid_next = 1'b1;
                dest_next      = DEST_SEND;
                cnt_next       = cnt_reg + 1'b1;
                case (cnt_reg)
                    REPLY_VERB:
                    begin
                        byte_next = verb_reg;
                        last_next = 1'b0;
                    end
                    REPLY_OPT:
                    begin
                        byte_next = opt_reg;
                        last_next = 1'b0;
                    end
                    default:
                    begin
                        byte_next = '0;
                        last_next = 1'b1;
                        busy_next = 1'b0;
                    end
                endcase
            end
            else if (!empty)
            begin
                out_valid_next = 1'b1;
                case (head.kind)
                    ACT_REFUSE:
                    begin
                        dest_next = DEST_SEND;
                        byte_next = CODE_IAC;
                        last_next = 1'b0;
                        busy_next = 1'b1;
                        cnt_next  = REPLY_VERB;
                        verb_next = head.verb;
                        opt_next  = head.data;
                    end
                    ACT_CLOSE:
                    begin
                        dest_next = DEST_CLOSE;
                        byte_next = '0;
                        last_next = 1'b1;
                    end
                    default:
                    begin
                        dest_next = DEST_CONSOLE;
                        byte_next = head.data;
                        last_next = 1'b1;
                    end
                endcase
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            cnt_reg       <= REPLY_LAST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg <= dest_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        verb_reg <= verb_next;
        opt_reg  <= opt_next;
    end

endmodule

// ===== hdl/telnet_option_refuser_with_idle_drop.sv =====
// Top level of the telnet option refuser with idle drop.
// Takes received telnet bytes and poll ticks, one item per cycle. Data bytes and
// IAC IAC come out one result per cycle while the receiver is ready; option requests
// (WILL/WONT/DO/DONT x) are refused with the four-byte reply IAC DONT|WONT x 0.
// The result port moves one item per cycle while the receiver is ready and sets the
// sustained rate: a two-entry action queue lets the parser keep taking input while a
// reply drains, and input stalls only when that queue fills. A tick that reaches
// max_idle_ticks (reset 60, zero disables) yields one close result and returns the
// parser and idle count to reset. No clearing pass after reset; the block accepts
// items from the first cycle after rst_n rises.
module telnet_option_refuser_with_idle_drop import tnref_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tnref_in_if.sink    request,
    tnref_out_if.source response,
    tnref_cfg_if.sink   cfg
);

    logic    push;
    action_t act;
    logic    q_full;
    logic    q_empty;
    logic    pop;
    action_t head;

    tnref_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cfg     (cfg),
        .q_full  (q_full),
        .push    (push),
        .act     (act)
    );

    tnref_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (act),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    tnref_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .head     (head),
        .pop      (pop),
        .response (response)
    );

endmodule

// ===== bench/tnref_checker.sv =====
// Checker for the telnet refuser: predicts results of accepted items and compares them.
`timescale 1ns / 100ps

module tnref_checker import tnref_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    tnref_in_if   request,
    tnref_out_if  response,
    tnref_cfg_if  cfg,
    output int    mismatches,
    output int    outstanding,
    output int    items_in,
    output int    results_ok,
    output int    closes_seen
);

    typedef enum logic [2:0] {
        PS_NORMAL = 3'd0,
        PS_IAC    = 3'd1,
        PS_WILL   = 3'd2,
        PS_WONT   = 3'd3,
        PS_DO     = 3'd4,
        PS_DONT   = 3'd5
    } parse_state_t;

    typedef struct {
        dest_t                 dest;
        logic [BYTE_WIDTH-1:0] data;
        logic                  last;
    } tn_result_t;

    tn_result_t            due_results[$];
    parse_state_t          ps;
    logic [IDLE_WIDTH-1:0] idle_cnt;
    logic [CFG_WIDTH-1:0]  idle_limit;

    task automatic owe(input dest_t d, input logic [BYTE_WIDTH-1:0] b, input logic l);
        tn_result_t r;
        r.dest = d;
        r.data = b;
        r.last = l;
        due_results.push_back(r);
    endtask

    task automatic owe_refusal(input logic [BYTE_WIDTH-1:0] verb,
                               input logic [BYTE_WIDTH-1:0] opt);
        owe(DEST_SEND, CODE_IAC, 1'b0);
        owe(DEST_SEND, verb, 1'b0);
        owe(DEST_SEND, opt, 1'b0);
        owe(DEST_SEND, '0, 1'b1);
    endtask

    task automatic predict_item(input logic cmd, input logic [BYTE_WIDTH-1:0] c);
        if (cmd == CMD_TICK) begin
            if (idle_limit != '0) begin
                if (idle_cnt != '1)
                    idle_cnt = idle_cnt + 1'b1;
                if (idle_cnt >= idle_limit) begin
                    ps = PS_NORMAL;
                    idle_cnt = '0;
                    owe(DEST_CLOSE, '0, 1'b1);
                end
            end
        end
        else begin
            idle_cnt = '0;
            case (ps)
                PS_IAC:
                begin
                    if (c == CODE_IAC) begin
                        ps = PS_NORMAL;
                        owe(DEST_CONSOLE, CODE_IAC, 1'b1);
                    end
                    else if (c == CODE_WILL)
                        ps = PS_WILL;
                    else if (c == CODE_WONT)
                        ps = PS_WONT;
                    else if (c == CODE_DO)
                        ps = PS_DO;
                    else if (c == CODE_DONT)
                        ps = PS_DONT;
                    else
                        ps = PS_NORMAL;
                end
                PS_WILL, PS_WONT:
                begin
                    ps = PS_NORMAL;
                    owe_refusal(CODE_DONT, c);
                end
                PS_DO, PS_DONT:
                begin
                    ps = PS_NORMAL;
                    owe_refusal(CODE_WONT, c);
                end
                default:
                begin
                    if (c == CODE_IAC)
                        ps = PS_IAC;
                    else begin
                        ps = PS_NORMAL;
                        owe(DEST_CONSOLE, c, 1'b1);
                    end
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tn_result_t want;
        if (!rst_n) begin
            due_results.delete();
            ps          = PS_NORMAL;
            idle_cnt    = '0;
            idle_limit  = MAX_IDLE_RESET;
            mismatches  = 0;
            outstanding = 0;
            items_in    = 0;
            results_ok  = 0;
            closes_seen = 0;
        end
        else begin
            if (cfg.valid && cfg.ready)
                idle_limit = cfg.max_idle_ticks;
            if (request.valid && request.ready) begin
                items_in++;
                predict_item(request.command, request.data_byte);
            end
            if (response.valid && response.ready) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected item dest=%0d byte=%02h last=%0b", $realtime,
                                 response.destination, response.out_byte,
                                 response.last_of_run);
                end
                else begin
                    want = due_results.pop_front();
                    if (response.destination !== want.dest || response.out_byte !== want.data ||
                        response.last_of_run !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp %0d/%02h/%0b got %0d/%02h/%0b",
                                     $realtime, want.dest, want.data, want.last,
                                     response.destination, response.out_byte,
                                     response.last_of_run);
                    end
                    else begin
                        results_ok++;
                        if (want.dest == DEST_CLOSE)
                            closes_seen++;
                    end
                end
            end
            outstanding = due_results.size();
        end
    end

endmodule

// ===== bench/tb_telnet_option_refuser_with_idle_drop.sv =====
// Testbench top for the telnet refuser: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_telnet_option_refuser_with_idle_drop;
    import tnref_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PH  = 48;

    logic clk;
    logic rst_n;

    tnref_in_if  request ();
    tnref_out_if response ();
    tnref_cfg_if cfg ();

    int mismatches;
    int outstanding;
    int items_in;
    int results_ok;
    int closes_seen;

    int snd_idle_pct;
    int rcv_stall_pct;
    int offered;
    logic [CFG_WIDTH-1:0] cur_limit;
    logic hold_go;
    logic holding;

    telnet_option_refuser_with_idle_drop dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response),
        .cfg      (cfg)
    );

    tnref_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .response    (response),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .items_in    (items_in),
        .results_ok  (results_ok),
        .closes_seen (closes_seen)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial response.ready = 1'b0;
    always @(negedge clk)
        response.ready <= !holding && ($urandom_range(99) >= rcv_stall_pct);

    // long receiver hold-off, counted at the rising edge
    initial
    begin
        holding = 1'b0;
        wait (hold_go);
        @(posedge clk);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("** telnet_option_refuser_with_idle_drop: FAILED **");
        $finish;
    end

    task automatic push_item(input logic cmd, input logic [BYTE_WIDTH-1:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            request.valid <= 1'b0;
            @(negedge clk);
        end
        request.valid     <= 1'b1;
        request.command   <= cmd;
        request.data_byte <= b;
        @(posedge clk);
        while (!request.ready) @(posedge clk);
        @(negedge clk);
        if (!(cmd == CMD_TICK && cur_limit == '0))
            offered++;
    endtask

    task automatic push_byte(input logic [BYTE_WIDTH-1:0] b);
        push_item(CMD_BYTE, b);
    endtask

    task automatic push_tick();
        push_item(CMD_TICK, BYTE_WIDTH'($urandom_range(255)));
    endtask

    task automatic set_idle_limit(input logic [CFG_WIDTH-1:0] v);
        request.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg.valid          <= 1'b1;
        cfg.max_idle_ticks <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        cur_limit = v;
    endtask

    function automatic logic [BYTE_WIDTH-1:0] pick_verb();
        case ($urandom_range(3))
            0:       return CODE_WILL;
            1:       return CODE_WONT;
            2:       return CODE_DO;
            default: return CODE_DONT;
        endcase
    endfunction

    task automatic offer_sequence();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 35)
            push_byte(BYTE_WIDTH'($urandom_range(254)));
        else if (r < 45) begin
            push_byte(CODE_IAC);
            push_byte(CODE_IAC);
        end
        else if (r < 75) begin
            push_byte(CODE_IAC);
            push_byte(pick_verb());
            push_byte(BYTE_WIDTH'($urandom_range(255)));
        end
        else if (r < 82) begin
            push_byte(CODE_IAC);
            push_byte(BYTE_WIDTH'($urandom_range(250)));
        end
        else if (r < 94) begin
            if (cur_limit != '0 && cur_limit <= 8)
                len = $urandom_range(int'(cur_limit) + 1, 1);
            else if (cur_limit != '0 && cur_limit <= 64 && $urandom_range(9) == 0)
                len = int'(cur_limit);
            else
                len = $urandom_range(3, 1);
            repeat (len) push_tick();
        end
        else if (r < 97) begin
            // negotiation broken by a tick
            push_byte(CODE_IAC);
            push_tick();
            push_byte(pick_verb());
            push_tick();
            push_byte(BYTE_WIDTH'($urandom_range(255)));
        end
        else
            push_item(1'($urandom_range(1)), BYTE_WIDTH'($urandom_range(255)));
    endtask

    initial
    begin
        request.valid      = 1'b0;
        request.command    = CMD_BYTE;
        request.data_byte  = '0;
        cfg.valid          = 1'b0;
        cfg.max_idle_ticks = '0;
        snd_idle_pct       = 0;
        rcv_stall_pct      = 0;
        offered            = 0;
        cur_limit          = MAX_IDLE_RESET;
        hold_go            = 1'b0;
        rst_n              = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: plain bytes, escapes, every refusal, dropped command
        push_byte(8'h00);
        push_byte(8'hFE);
        push_byte(8'h7F);
        push_byte(CODE_IAC);
        push_byte(CODE_IAC);
        push_byte(CODE_IAC);
        push_byte(CODE_WILL);
        push_byte(8'h00);
        push_byte(CODE_IAC);
        push_byte(CODE_WONT);
        push_byte(CODE_IAC);
        push_byte(CODE_IAC);
        push_byte(CODE_DO);
        push_byte(8'h18);
        push_byte(CODE_IAC);
        push_byte(CODE_DONT);
        push_byte(8'h01);
        push_byte(CODE_IAC);
        push_byte(8'hF1);
        push_byte(8'h41);
        push_tick();

        // close resets the parser mid-sequence
        set_idle_limit(16'd1);
        push_byte(CODE_IAC);
        push_tick();
        push_byte(CODE_WILL);
        push_tick();

        set_idle_limit(16'd0);
        push_tick();
        push_tick();

        set_idle_limit(16'hFFFF);
        push_tick();
        push_tick();
        push_byte(8'h80);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:
                begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct = 0;
                    set_idle_limit(MAX_IDLE_RESET);
                end
                1:
                begin
                    snd_idle_pct  = 67;
                    rcv_stall_pct = 0;
                    set_idle_limit(16'd3);
                end
                2:
                begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct = 67;
                    set_idle_limit(16'd0);
                    hold_go = 1'b1;
                end
                default:
                begin
                    snd_idle_pct  = 10;
                    rcv_stall_pct = 10;
                    set_idle_limit(16'd5);
                end
            endcase
            offered = 0;
            while (offered < ITEMS_PER_PH)
                offer_sequence();
        end

        request.valid <= 1'b0;
        rcv_stall_pct = 0;
        while (outstanding != 0) @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Run covered %0d input items and %0d checked results (%0d idle closes).",
                 items_in, results_ok, closes_seen);
        $display("Idle limits 0, 1, 3, 5, 60 and 65535; %0d mismatches.", mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("** telnet_option_refuser_with_idle_drop: PASSED **");
        else
            $display("** telnet_option_refuser_with_idle_drop: FAILED **");
        $finish;
    end

endmodule
